FILE: rtl/sibrl_pkg.sv
// ----------------------------------------------------------------------------
// sibrl_pkg
// Shared types, codes and constants for the source blocklist rate limiter.
// ----------------------------------------------------------------------------
package sibrl_pkg;

	// ethertype and reset limit
	localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;
	localparam logic [31:0] LIMIT_RESET    = 32'd100000;

	// private ranges: 10/8, 192.168/16, 172.16/12
	localparam logic [31:0] MASK_8   = 32'hFF000000;
	localparam logic [31:0] NET_10   = 32'h0A000000;
	localparam logic [31:0] MASK_16  = 32'hFFFF0000;
	localparam logic [31:0] NET_192  = 32'hC0A80000;
	localparam logic [31:0] MASK_12  = 32'hFFF00000;
	localparam logic [31:0] NET_172  = 32'hAC100000;

	// result cause codes
	typedef enum logic [2:0] {
		CAUSE_NOT_IPV4   = 3'd0,
		CAUSE_BLOCKED    = 3'd1,
		CAUSE_OVER_LIMIT = 3'd2,
		CAUSE_INTERNAL   = 3'd3,
		CAUSE_NORMAL     = 3'd4,
		CAUSE_TABLE_FULL = 3'd5
	} cause_t;

	// which result the datapath builds on finish
	typedef enum logic [1:0] {
		FIN_BYPASS,
		FIN_CREATE,
		FIN_UPDATE
	} fin_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     scan_first;
		logic     scan_next;
		logic     rec_read;
		logic     finish;
		fin_sel_t fin_sel;
		cause_t   bypass_cause;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_ipv4;
		logic table_empty;
		logic table_full;
		logic match;
		logic scan_last;
	} sts_t;

	function automatic logic is_private(input logic [31:0] a);
		return ((a & MASK_8) == NET_10) || ((a & MASK_16) == NET_192) ||
			((a & MASK_12) == NET_172);
	endfunction

endpackage

FILE: rtl/source_ip_blocklist_rate_limiter.sv
// ----------------------------------------------------------------------------
// source_ip_blocklist_rate_limiter
// Per-source IPv4 blocklist and packet-count limiter over a table of
// per-source counters, searched linearly.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  item in  | start & !busy          | ether_type, header_complete, addresses
//  config   | cfg_valid & cfg_ready  | cfg_data (packet_limit)
//  result   | result_valid, 1 cycle  | verdict, cause, four totals
//
// A non-IPv4 item gives its result the cycle after acceptance, busy stays low.
// An IPv4 item scans n entries, n the number of entries scanned (one source
// memory read per cycle), at most TABLE_ENTRIES, then an update or create state;
// busy covers both, and the result shows as busy drops, when a new item is taken.
// Reset clears the fill count, not the memories, and sets the limit to LIMIT_RESET;
// no clearing pass is needed. The receiver cannot stall; the result is shown for
// exactly one cycle.
module source_ip_blocklist_rate_limiter import sibrl_pkg::*; #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int COUNT_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] ether_type,
	input  logic        header_complete,
	input  logic [31:0] source_address,
	input  logic [31:0] dest_address,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output logic        result_valid,
	output logic        verdict,
	output logic [2:0]  cause,
	output logic [31:0] drop_total,
	output logic [31:0] pass_total,
	output logic [31:0] packet_total,
	output logic [31:0] class_total
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	sibrl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	sibrl_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.COUNT_BITS    (COUNT_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.ether_type      (ether_type),
		.header_complete (header_complete),
		.source_address  (source_address),
		.dest_address    (dest_address),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.result_valid    (result_valid),
		.verdict         (verdict),
		.cause           (cause),
		.drop_total      (drop_total),
		.pass_total      (pass_total),
		.packet_total    (packet_total),
		.class_total     (class_total)
	);

endmodule

FILE: rtl/sibrl_dp.sv
// ----------------------------------------------------------------------------
// sibrl_dp
// Datapath: source and record memories, scan index, fill count, limit
// register, counter update and result registers.
// ----------------------------------------------------------------------------
module sibrl_dp import sibrl_pkg::*; #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int COUNT_BITS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [15:0] ether_type,
	input  logic        header_complete,
	input  logic [31:0] source_address,
	input  logic [31:0] dest_address,
	input  logic        cfg_valid,
	input  logic [31:0] cfg_data,
	output logic        result_valid,
	output logic        verdict,
	output logic [2:0]  cause,
	output logic [31:0] drop_total,
	output logic [31:0] pass_total,
	output logic [31:0] packet_total,
	output logic [31:0] class_total
);

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
	localparam int CB     = COUNT_BITS;
	localparam int CMP_W  = (COUNT_BITS > 32) ? COUNT_BITS : 32;

	typedef struct packed {
		logic          blocked;
		logic [CB-1:0] packets;
		logic [CB-1:0] drops;
		logic [CB-1:0] passes;
		logic [CB-1:0] normal;
		logic [CB-1:0] internal;
	} rec_t;

	logic [31:0]       src_mem [TABLE_ENTRIES];
	rec_t              rec_mem [TABLE_ENTRIES];
	logic [31:0]       src_rd_q;
	rec_t              rec_rd_q;
	logic [IDX_W-1:0]  idx_q;
	logic [USED_W-1:0] used_q;
	logic [31:0]       limit_q;
	logic [31:0]       src_q;
	logic              internal_q;
	logic              res_valid_q;
	logic              verdict_q;
	cause_t            cause_q;
	logic [31:0]       drop_q, pass_q, pkt_q, cls_q;

	logic [IDX_W-1:0]  idx_nxt;
	logic [IDX_W-1:0]  wr_addr;
	logic              rec_we, src_we;
	rec_t              rec_new;
	logic              v_new;
	cause_t            c_new;
	logic [CB-1:0]     d_new, p_new, k_new, cl_new;

	function automatic logic [CB-1:0] bump(input logic [CB-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [31:0] clamp(input logic [CB-1:0] v);
		logic [CMP_W-1:0] e;
		e = CMP_W'(v);
		return (e > CMP_W'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : e[31:0];
	endfunction

	// status to the controller
	assign idx_nxt         = idx_q + 1'b1;
	assign sts.in_ipv4     = (ether_type == IPV4_ETHERTYPE) && header_complete;
	assign sts.table_empty = (used_q == '0);
	assign sts.table_full  = (used_q == USED_W'(TABLE_ENTRIES));
	assign sts.match       = (src_rd_q == src_q);
	assign sts.scan_last   = ((USED_W'(idx_q) + 1'b1) == used_q);

	// result and record update
	always_comb begin
		rec_t r;
		logic [CB-1:0] pk_b, dr_b;
		r       = rec_rd_q;
		pk_b    = bump(r.packets);
		dr_b    = bump(r.drops);
		rec_new = r;
		v_new   = 1'b0;
		c_new   = cmd.bypass_cause;
		d_new   = '0;
		p_new   = '0;
		k_new   = '0;
		cl_new  = '0;
		case (cmd.fin_sel)
			FIN_CREATE: begin
				rec_new.blocked  = 1'b0;
				rec_new.packets  = CB'(1);
				rec_new.drops    = '0;
				rec_new.passes   = CB'(1);
				rec_new.normal   = CB'(!internal_q);
				rec_new.internal = CB'(internal_q);
				c_new  = internal_q ? CAUSE_INTERNAL : CAUSE_NORMAL;
				p_new  = CB'(1);
				k_new  = CB'(1);
				cl_new = CB'(1);
			end
			FIN_UPDATE: begin
				if (r.blocked) begin
					rec_new.drops = dr_b;
					v_new = 1'b1;
					c_new = CAUSE_BLOCKED;
					d_new = dr_b;
					p_new = r.passes;
					k_new = r.packets;
				end else if (CMP_W'(pk_b) > CMP_W'(limit_q)) begin
					rec_new.packets = pk_b;
					rec_new.blocked = 1'b1;
					rec_new.drops   = dr_b;
					v_new = 1'b1;
					c_new = CAUSE_OVER_LIMIT;
					d_new = dr_b;
					p_new = r.passes;
					k_new = pk_b;
				end else begin
					rec_new.packets = pk_b;
					rec_new.passes  = bump(r.passes);
					if (internal_q) begin
						rec_new.internal = bump(r.internal);
						cl_new = rec_new.internal;
					end else begin
						rec_new.normal = bump(r.normal);
						cl_new = rec_new.normal;
					end
					c_new = internal_q ? CAUSE_INTERNAL : CAUSE_NORMAL;
					d_new = r.drops;
					p_new = rec_new.passes;
					k_new = pk_b;
				end
			end
			default: begin
			end
		endcase
	end

	assign rec_we  = cmd.finish && (cmd.fin_sel == FIN_CREATE || cmd.fin_sel == FIN_UPDATE);
	assign src_we  = cmd.finish && (cmd.fin_sel == FIN_CREATE);
	assign wr_addr = (cmd.fin_sel == FIN_CREATE) ? used_q[IDX_W-1:0] : idx_q;

	// memories
	always_ff @(posedge clk) begin
		if (src_we) src_mem[wr_addr] <= src_q;
		if (rec_we) rec_mem[wr_addr] <= rec_new;
		if (cmd.scan_first) begin
			src_rd_q <= src_mem[0];
		end else if (cmd.scan_next) begin
			src_rd_q <= src_mem[idx_nxt];
		end
		if (cmd.rec_read) rec_rd_q <= rec_mem[idx_q];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			limit_q     <= LIMIT_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) limit_q <= cfg_data;
			if (src_we) used_q <= used_q + 1'b1;
			res_valid_q <= cmd.finish;
		end
	end

	// item capture, scan index and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q      <= source_address;
			internal_q <= is_private(source_address) && is_private(dest_address);
		end
		if (cmd.scan_first) begin
			idx_q <= '0;
		end else if (cmd.scan_next) begin
			idx_q <= idx_nxt;
		end
		if (cmd.finish) begin
			verdict_q <= v_new;
			cause_q   <= c_new;
			drop_q    <= clamp(d_new);
			pass_q    <= clamp(p_new);
			pkt_q     <= clamp(k_new);
			cls_q     <= clamp(cl_new);
		end
	end

	assign result_valid = res_valid_q;
	assign verdict      = verdict_q;
	assign cause        = cause_q;
	assign drop_total   = drop_q;
	assign pass_total   = pass_q;
	assign packet_total = pkt_q;
	assign class_total  = cls_q;

	// checks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(TABLE_ENTRIES)) else $error("fill count over table size");
	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		used_q != $past(used_q) |-> used_q == $past(used_q) + 1'b1)
		else $error("fill count jumped");
	a_update_idx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && cmd.fin_sel == FIN_UPDATE |-> USED_W'(idx_q) < used_q)
		else $error("update beyond filled entries");
	a_drop_cause: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && verdict_q |-> cause_q == CAUSE_BLOCKED ||
		cause_q == CAUSE_OVER_LIMIT) else $error("drop with pass cause");

endmodule

FILE: rtl/sibrl_ctrl.sv
// ----------------------------------------------------------------------------
// sibrl_ctrl
// Controller: sequences capture, table scan, record fetch and write-back.
// ----------------------------------------------------------------------------
module sibrl_ctrl import sibrl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_CREATE
	} state_t;

	state_t state_q, state_d;
	logic   busy_q;

	// next state and commands
	always_comb begin
		state_d          = state_q;
		cmd              = '0;
		cmd.fin_sel      = FIN_BYPASS;
		cmd.bypass_cause = CAUSE_NOT_IPV4;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (!sts.in_ipv4) begin
						cmd.finish = 1'b1;
					end else if (sts.table_empty) begin
						state_d = ST_CREATE;
					end else begin
						cmd.scan_first = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (sts.match) begin
					cmd.rec_read = 1'b1;
					state_d = ST_UPDATE;
				end else if (sts.scan_last) begin
					state_d = ST_CREATE;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			ST_UPDATE: begin
				cmd.finish  = 1'b1;
				cmd.fin_sel = FIN_UPDATE;
				state_d = ST_IDLE;
			end
			ST_CREATE: begin
				cmd.finish = 1'b1;
				if (sts.table_full) begin
					cmd.bypass_cause = CAUSE_TABLE_FULL;
				end else begin
					cmd.fin_sel = FIN_CREATE;
				end
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
		end
	end

	assign busy = busy_q;

	// checks
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != ST_IDLE)) else $error("busy out of step");
	a_one_finish: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE || state_q == ST_CREATE |-> cmd.finish)
		else $error("terminal state without result");
	a_scan_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_first |-> state_q == ST_IDLE && start) else $error("stray scan");

endmodule
